@@ rtl/tbc_pkg.sv @@
// Shared widths, item kind codes and register indexes for the triangle/box cull block.
// No dependencies; the item and register-write interfaces and the top level import it.
package tbc_pkg;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned NUM_AXES  = 3;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRI   = 2'd2;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_X = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_Y = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_Z = 3'd5;

  // seeds in Q23.8, before saturation to the coordinate width
  localparam longint MESH_LOW_SEED  = 64'sd25600000;
  localparam longint MESH_HIGH_SEED = -64'sd256000000;
  localparam longint TRI_LOW_SEED   = 64'sd7680000;
  localparam longint TRI_HIGH_SEED  = -64'sd7680000;

endpackage

@@ rtl/tbc_if.sv @@
// Valid/ready channel interfaces of the triangle/box cull block: item, result, register write.
// Depends on tbc_pkg for the fixed field widths.
interface tbc_in_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  import tbc_pkg::*;

  logic                             valid;
  logic                             ready;
  logic        [KIND_W-1:0]         kind;
  logic        [INDEX_W-1:0]        vertex_slot;
  logic signed [COORD_WIDTH-1:0]    coord_x;
  logic signed [COORD_WIDTH-1:0]    coord_y;
  logic signed [COORD_WIDTH-1:0]    coord_z;
  logic        [INDEX_W-1:0]        corner_a_index;
  logic        [INDEX_W-1:0]        corner_b_index;
  logic        [INDEX_W-1:0]        corner_c_index;

  modport source (
    output valid, kind, vertex_slot, coord_x, coord_y, coord_z,
           corner_a_index, corner_b_index, corner_c_index,
    input  ready
  );
  modport sink (
    input  valid, kind, vertex_slot, coord_x, coord_y, coord_z,
           corner_a_index, corner_b_index, corner_c_index,
    output ready
  );
endinterface

interface tbc_out_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          triangle_hit;
  logic signed [COORD_WIDTH-1:0] mesh_low_x;
  logic signed [COORD_WIDTH-1:0] mesh_low_y;
  logic signed [COORD_WIDTH-1:0] mesh_low_z;
  logic signed [COORD_WIDTH-1:0] mesh_high_x;
  logic signed [COORD_WIDTH-1:0] mesh_high_y;
  logic signed [COORD_WIDTH-1:0] mesh_high_z;

  modport source (
    output valid, triangle_hit, mesh_low_x, mesh_low_y, mesh_low_z,
           mesh_high_x, mesh_high_y, mesh_high_z,
    input  ready
  );
  modport sink (
    input  valid, triangle_hit, mesh_low_x, mesh_low_y, mesh_low_z,
           mesh_high_x, mesh_high_y, mesh_high_z,
    output ready
  );
endinterface

interface tbc_cfg_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  import tbc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_ADDR_W-1:0]  addr;
  logic [COORD_WIDTH-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ rtl/triangle_box_overlap_cull.sv @@
// Top level of the triangle/box cull block: vertex memory, mesh bounds, sequencer, shared fold unit.
// Depends on tbc_pkg and on the channel interfaces in tbc_if.sv.
//
// Channel | Dir | Word
// --------+-----+--------------------------------------------------------------
// in_i    | in  | kind, vertex_slot, coord_x/y/z, corner_a/b/c_index
// out_o   | out | triangle_hit, mesh_low_x/y/z, mesh_high_x/y/z (one per item)
// cfg_i   | in  | addr (query register 0..5), data; always ready
//
// One item at a time. A clear or an unused kind goes straight to the result, a load first
// writes and folds its vertex, and a triangle reads its corners from the single-port vertex
// memory, one corner a cycle with registered data, into the one min/max fold unit that takes
// one corner a cycle, then tests its box; each result waits on out_o while it is stalled.
// Reset is asynchronous, active low; it returns the mesh bounds to their seeds and the query
// box to zero. The vertex memory is not cleared: an unwritten entry reads as anything.
// in_i is held off while an item is in work or its result waits on out_o.
module triangle_box_overlap_cull #(
  parameter int unsigned VERTEX_DEPTH = 4096,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tbc_in_if.sink    in_i,
  tbc_out_if.source out_o,
  tbc_cfg_if.sink   cfg_i
);
  import tbc_pkg::*;

  localparam int unsigned ADDR_W   = $clog2(VERTEX_DEPTH);
  localparam int unsigned VERTEX_W = NUM_AXES * COORD_WIDTH;

  // seeds saturated to the coordinate range
  localparam longint CMAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam logic signed [COORD_WIDTH-1:0] MESH_LO = COORD_WIDTH'(
    (MESH_LOW_SEED > CMAX) ? CMAX : (MESH_LOW_SEED < CMIN) ? CMIN : MESH_LOW_SEED);
  localparam logic signed [COORD_WIDTH-1:0] MESH_HI = COORD_WIDTH'(
    (MESH_HIGH_SEED > CMAX) ? CMAX : (MESH_HIGH_SEED < CMIN) ? CMIN : MESH_HIGH_SEED);
  localparam logic signed [COORD_WIDTH-1:0] TRI_LO = COORD_WIDTH'(
    (TRI_LOW_SEED > CMAX) ? CMAX : (TRI_LOW_SEED < CMIN) ? CMIN : TRI_LOW_SEED);
  localparam logic signed [COORD_WIDTH-1:0] TRI_HI = COORD_WIDTH'(
    (TRI_HIGH_SEED > CMAX) ? CMAX : (TRI_HIGH_SEED < CMIN) ? CMIN : TRI_HIGH_SEED);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_TRI  = 3'd2;
  localparam logic [2:0] ST_TEST = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [1:0] LAST_STEP = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] step_q,  step_d;

  // captured item
  logic        [INDEX_W-1:0]     slot_q;
  logic signed [COORD_WIDTH-1:0] pt_q     [NUM_AXES];
  logic        [INDEX_W-1:0]     corner_q [NUM_AXES];

  // query box and mesh bounds
  logic signed [COORD_WIDTH-1:0] qlo_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] qhi_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] blo_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] bhi_q [NUM_AXES];

  // triangle box under construction
  logic signed [COORD_WIDTH-1:0] tlo_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] thi_q [NUM_AXES];

  logic hit_q;

  // vertex memory, single port with registered read
  logic [VERTEX_W-1:0] vtx_mem_q [VERTEX_DEPTH];
  logic [VERTEX_W-1:0] rd_data_q;
  logic                rd_oob_q;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [VERTEX_W-1:0] mem_wdata;

  logic [31:0] slot_ext;
  logic [31:0] corner_ext;
  logic        slot_ok;
  logic        corner_ok;

  // shared fold unit
  logic signed [COORD_WIDTH-1:0] fold_pt [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] fold_lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] fold_hi [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] new_lo  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] new_hi  [NUM_AXES];

  logic in_fire;
  logic test_hit;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign slot_ext   = 32'(slot_q);
  assign corner_ext = 32'(corner_q[0]);
  assign slot_ok    = slot_ext < 32'(VERTEX_DEPTH);
  assign corner_ok  = corner_ext < 32'(VERTEX_DEPTH);

  // write a load's vertex; read the front corner while a triangle steps
  assign mem_we    = (state_q == ST_LOAD) && slot_ok;
  assign mem_re    = (state_q == ST_TRI) && (step_q != LAST_STEP);
  assign mem_addr  = (state_q == ST_LOAD) ? slot_ext[ADDR_W-1:0] : corner_ext[ADDR_W-1:0];
  assign mem_wdata = {pt_q[2], pt_q[1], pt_q[0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vtx_mem_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_data_q <= vtx_mem_q[mem_addr];
    end
  end

  // fold unit: a load folds its point into the mesh bounds, a triangle folds each corner
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (state_q == ST_LOAD) begin
        fold_pt[a] = pt_q[a];
        fold_lo[a] = blo_q[a];
        fold_hi[a] = bhi_q[a];
      end else begin
        fold_pt[a] = rd_oob_q ? '0 : $signed(rd_data_q[a*COORD_WIDTH +: COORD_WIDTH]);
        fold_lo[a] = tlo_q[a];
        fold_hi[a] = thi_q[a];
      end
      new_lo[a] = (fold_pt[a] < fold_lo[a]) ? fold_pt[a] : fold_lo[a];
      new_hi[a] = (fold_pt[a] > fold_hi[a]) ? fold_pt[a] : fold_hi[a];
    end
  end

  // inclusive overlap on every axis
  always_comb begin
    test_hit = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!(thi_q[a] >= qlo_q[a] && tlo_q[a] <= qhi_q[a])) begin
        test_hit = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          step_d = '0;
          unique case (in_i.kind)
            KIND_LOAD: state_d = ST_LOAD;
            KIND_TRI:  state_d = ST_TRI;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_LOAD: state_d = ST_OUT;
      ST_TRI: begin
        step_d = step_q + 2'd1;
        if (step_q == LAST_STEP) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: state_d = ST_OUT;
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control, registers and mesh bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      hit_q   <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        qlo_q[a] <= '0;
        qhi_q[a] <= '0;
        blo_q[a] <= MESH_LO;
        bhi_q[a] <= MESH_HI;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.addr)
          CFG_MIN_X: qlo_q[0] <= $signed(cfg_i.data);
          CFG_MIN_Y: qlo_q[1] <= $signed(cfg_i.data);
          CFG_MIN_Z: qlo_q[2] <= $signed(cfg_i.data);
          CFG_MAX_X: qhi_q[0] <= $signed(cfg_i.data);
          CFG_MAX_Y: qhi_q[1] <= $signed(cfg_i.data);
          CFG_MAX_Z: qhi_q[2] <= $signed(cfg_i.data);
          default: ;
        endcase
      end

      if (in_fire) begin
        hit_q <= 1'b0;
        if (in_i.kind == KIND_CLEAR) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            blo_q[a] <= MESH_LO;
            bhi_q[a] <= MESH_HI;
          end
        end
      end

      if (mem_we) begin
        blo_q <= new_lo;
        bhi_q <= new_hi;
      end

      if (state_q == ST_TEST) begin
        hit_q <= test_hit;
      end
    end
  end

  // item capture and triangle datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slot_q      <= in_i.vertex_slot;
      pt_q[0]     <= in_i.coord_x;
      pt_q[1]     <= in_i.coord_y;
      pt_q[2]     <= in_i.coord_z;
      corner_q[0] <= in_i.corner_a_index;
      corner_q[1] <= in_i.corner_b_index;
      corner_q[2] <= in_i.corner_c_index;
      for (int a = 0; a < NUM_AXES; a++) begin
        tlo_q[a] <= TRI_LO;
        thi_q[a] <= TRI_HI;
      end
    end else if (state_q == ST_TRI) begin
      // advance the corner queue; the front is read this cycle
      rd_oob_q    <= !corner_ok;
      corner_q[0] <= corner_q[1];
      corner_q[1] <= corner_q[2];
      // fold the corner whose data came back this cycle
      if (step_q != '0) begin
        tlo_q <= new_lo;
        thi_q <= new_hi;
      end
    end
  end

  assign out_o.valid        = (state_q == ST_OUT);
  assign out_o.triangle_hit = hit_q;
  assign out_o.mesh_low_x   = blo_q[0];
  assign out_o.mesh_low_y   = blo_q[1];
  assign out_o.mesh_low_z   = blo_q[2];
  assign out_o.mesh_high_x  = bhi_q[0];
  assign out_o.mesh_high_y  = bhi_q[1];
  assign out_o.mesh_high_z  = bhi_q[2];

endmodule
